FILE: design/ntca_pkg.sv
// Shared types, constants and lookup functions for the nearest traffic announcer.
// No dependencies; imported by every module of the block.
package ntca_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CORDIC_STEPS = 16;

  localparam logic [1:0] REQ_STORE    = 2'd0;
  localparam logic [1:0] REQ_ANNOUNCE = 2'd1;
  localparam logic [1:0] REQ_SWEEP    = 2'd2;

  localparam logic [1:0] CFG_UNITS = 2'd0;
  localparam logic [1:0] CFG_VOICE = 2'd1;
  localparam logic [1:0] CFG_ENTRY = 2'd2;

  localparam logic [1:0] UNITS_KM_FT = 2'd1;
  localparam logic [1:0] UNITS_NM_FT = 2'd2;

  localparam logic [25:0] FEET_NUM = 26'd32808399;
  localparam logic [23:0] DEG45 = 24'd2949120;
  localparam logic [23:0] DEG90 = 24'd5898240;
  localparam logic [23:0] DEG180 = 24'd11796480;

  typedef struct packed {
    logic [23:0]        code;
    logic [31:0]        stamp;
    logic signed [15:0] north;
    logic signed [15:0] east;
    logic signed [15:0] vertical;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic [IDX_W-1:0] rd_idx;
  } tbl_ctrl_t;

  function automatic logic [21:0] atan_step(input logic [3:0] i);
    logic [21:0] r;
    case (i)
      4'd0:  r = 22'd2949120;
      4'd1:  r = 22'd1740967;
      4'd2:  r = 22'd919879;
      4'd3:  r = 22'd466945;
      4'd4:  r = 22'd234379;
      4'd5:  r = 22'd117304;
      4'd6:  r = 22'd58667;
      4'd7:  r = 22'd29335;
      4'd8:  r = 22'd14668;
      4'd9:  r = 22'd7334;
      4'd10: r = 22'd3667;
      4'd11: r = 22'd1833;
      4'd12: r = 22'd917;
      4'd13: r = 22'd458;
      4'd14: r = 22'd229;
      default: r = 22'd115;
    endcase
    return r;
  endfunction

  // squared distance of c whole units
  function automatic logic [31:0] dist_thr(input logic [3:0] c, input logic nm);
    logic [31:0] u2;
    logic [31:0] cc;
    u2 = nm ? 32'd3429904 : 32'd1000000;
    cc = 32'(c) * 32'(c);
    return 32'(cc * u2);
  endfunction

endpackage

FILE: design/ntca_table.sv
// Aircraft table: synchronous entry memory with per-slot occupancy flags.
// Depends on ntca_pkg.
module ntca_table (
  input  logic               clk,
  input  logic               rst,
  input  ntca_pkg::tbl_ctrl_t ctrl,
  input  ntca_pkg::entry_t   wr_data,
  output ntca_pkg::entry_t   rd_data,
  output logic [3:0]         live_count
);
  import ntca_pkg::*;

  entry_t           mem [SLOTS];
  entry_t           rd_raw;
  logic             rd_occ;
  logic [SLOTS-1:0] occ;
  logic [6:0]       sum;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_idx] <= wr_data;
    end
    rd_raw <= mem[ctrl.rd_idx];
    rd_occ <= occ[ctrl.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      if (ctrl.clr_en) begin
        occ[ctrl.clr_idx] <= 1'b0;
      end
      if (ctrl.wr_en) begin
        occ[ctrl.wr_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sum = sum + 7'(occ[i]);
    end
  end

  assign rd_data    = rd_occ ? rd_raw : '0;
  assign live_count = sum[3:0];

endmodule

FILE: design/ntca_cordic.sv
// Iterative vectoring CORDIC: first-octant angle in Q16 degrees, one step a cycle.
// Depends on ntca_pkg.
module ntca_cordic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] small_op,
  input  logic [16:0] big_op,
  output logic        done,
  output logic [23:0] angle
);
  import ntca_pkg::*;

  logic               run;
  logic [3:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [24:0] z;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [24:0] z_next;

  always_comb begin
    dx = y >>> step;
    dy = x >>> step;
    if (y >= 0) begin
      z_next = z + 25'(atan_step(step));
    end else begin
      z_next = z - 25'(atan_step(step));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        z    <= '0;
        x    <= 34'(big_op) <<< 14;
        y    <= 34'(small_op) <<< 14;
        if (small_op == 17'd0) begin
          angle <= '0;
          done  <= 1'b1;
        end else if (small_op == big_op) begin
          angle <= DEG45;
          done  <= 1'b1;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
        end else begin
          x <= x - dx;
          y <= y + dy;
        end
        z    <= z_next;
        step <= step + 4'd1;
        if (step == 4'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
          if (z_next < 0) begin
            angle <= '0;
          end else if (z_next > 25'(DEG45)) begin
            angle <= DEG45;
          end else begin
            angle <= z_next[23:0];
          end
        end
      end
    end
  end

endmodule

FILE: design/nearest_traffic_clock_announcer_top.sv
// Nearest traffic announcer top level: request sequencer, result formatting, output register.
// Depends on ntca_pkg, ntca_table and ntca_cordic.
//
//  channel  | direction | contents
//  s_*      | in        | request transaction, kind in tuser
//  m_*      | out       | one result transaction per request, announce flag in tuser
//  cfg_*    | in        | register writes, no handshake
//
// Store: accept, then S_OUT. Sweep: S_READ and S_CHECK for each slot (one memory read a slot).
// Announce: the same scan, then S_ANG and, for a new nearest target, the CORDIC (start, up to
// 16 steps, done), S_FIN1 and S_FIN2, before S_OUT. One request in flight; a held result
// stalls the sequencer.
// Reset empties the table at once through occupancy flags.
module nearest_traffic_clock_announcer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[2:0] aircraft_code[26:3] item_time[58:27] rel_north[74:59]
  // rel_east[90:75] rel_vertical[106:91] own_track[115:107]
  input  logic [119:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // clock_position[3:0] distance_near[4] distance_count[8:5] altitude_near[9]
  // altitude_hundreds[12:10] is_above[13] target_code[37:14] live_count[41:38]
  // dist_in_nm[42] alt_in_feet[43]
  output logic [47:0]  m_tdata,
  // announce[0]
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import ntca_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ANG   = 3'd3;
  localparam logic [2:0] S_CDC   = 3'd4;
  localparam logic [2:0] S_FIN1  = 3'd5;
  localparam logic [2:0] S_FIN2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state;
  logic [1:0]  units_mode;
  logic [15:0] voice_expiry;
  logic [15:0] entry_expiry;
  logic [23:0] last_announced;

  logic [1:0]  req;
  logic [31:0] now;
  logic [8:0]  track;
  logic [IDX_W-1:0] idx;

  logic              found;
  logic [31:0]       best_d2;
  logic [23:0]       best_code;
  logic signed [15:0] best_n;
  logic signed [15:0] best_e;
  logic signed [15:0] best_v;
  logic              swap;
  logic [16:0]       abs_v;
  logic [42:0]       alt_prod;
  logic [7:0]        deg;
  logic              neg;

  logic              r_announce;
  logic [3:0]        r_clock;
  logic              r_dnear;
  logic [3:0]        r_dcount;
  logic              r_anear;
  logic [2:0]        r_ahund;
  logic              r_above;
  logic [23:0]       r_code;
  logic              r_nm;
  logic              r_ft;

  tbl_ctrl_t   ctrl;
  entry_t      wr_data;
  entry_t      rd;
  logic [3:0]  live_count;

  logic        cdc_start;
  logic        cdc_done;
  logic [16:0] small_op;
  logic [16:0] big_op;
  logic [23:0] angle;

  logic        accept;
  logic [1:0]  in_req;
  logic [2:0]  in_slot;
  logic [23:0] in_code;
  logic        slot_ok;
  logic [IDX_W+2:0] slot_ext;
  logic [31:0] age;
  logic signed [31:0] nsq;
  logic signed [31:0] esq;
  logic [31:0] d2;
  logic        live;
  logic [16:0] an;
  logic [16:0] ae;
  logic        last_slot;

  assign in_req   = s_tuser;
  assign in_slot  = s_tdata[2:0];
  assign in_code  = s_tdata[26:3];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign slot_ext = {{IDX_W{1'b0}}, in_slot};
  assign slot_ok  = (32'(in_slot) < SLOTS);
  assign last_slot = (idx == IDX_W'(SLOTS - 1));

  assign wr_data.code     = in_code;
  assign wr_data.stamp    = s_tdata[58:27];
  assign wr_data.north    = s_tdata[74:59];
  assign wr_data.east     = s_tdata[90:75];
  assign wr_data.vertical = s_tdata[106:91];

  assign age = now - rd.stamp;
  assign nsq = rd.north * rd.north;
  assign esq = rd.east * rd.east;
  assign d2  = 32'(nsq) + 32'(esq);
  assign live = (rd.code != 24'd0) && (age <= {16'd0, voice_expiry});

  always_comb begin
    ctrl.wr_en   = accept && (in_req == REQ_STORE) && slot_ok && (in_code != 24'd0);
    ctrl.wr_idx  = slot_ext[IDX_W-1:0];
    ctrl.rd_idx  = idx;
    ctrl.clr_en  = 1'b0;
    ctrl.clr_idx = slot_ext[IDX_W-1:0];
    if (accept && (in_req == REQ_STORE) && slot_ok && (in_code == 24'd0)) begin
      ctrl.clr_en = 1'b1;
    end else if ((state == S_CHECK) && (req == REQ_SWEEP) && (rd.code != 24'd0)
                 && (age > {16'd0, entry_expiry})) begin
      ctrl.clr_en  = 1'b1;
      ctrl.clr_idx = idx;
    end
  end

  always_comb begin
    an = best_n[15] ? 17'(-{best_n[15], best_n}) : 17'({best_n[15], best_n});
    ae = best_e[15] ? 17'(-{best_e[15], best_e}) : 17'({best_e[15], best_e});
  end

  ntca_table u_table (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .wr_data    (wr_data),
    .rd_data    (rd),
    .live_count (live_count)
  );

  ntca_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cdc_start),
    .small_op (small_op),
    .big_op   (big_op),
    .done     (cdc_done),
    .angle    (angle)
  );

  // final formatting
  logic [23:0] q;
  logic [23:0] mag;
  logic [8:0]  course;
  logic [8:0]  tr;
  logic signed [10:0] rel;
  logic [9:0]  r15;
  logic [3:0]  clk_pos;
  logic        is_nm;
  logic        is_ft;
  logic [3:0]  dcount;
  logic [2:0]  ahund;

  always_comb begin
    q   = swap ? (DEG90 - angle) : angle;
    mag = best_e[15] ? (DEG180 - q) : q;
  end

  always_comb begin
    is_nm = (units_mode == UNITS_NM_FT);
    is_ft = (units_mode == UNITS_KM_FT) || (units_mode == UNITS_NM_FT);
    if (neg) begin
      course = 9'd90 + 9'(deg);
    end else if (deg <= 8'd90) begin
      course = 9'd90 - 9'(deg);
    end else begin
      course = 9'd450 - 9'(deg);
    end
    tr  = (track >= 9'd360) ? (track - 9'd360) : track;
    rel = 11'(course) - 11'(tr);
    if (rel < 0) begin
      rel = rel + 11'sd360;
    end
    r15 = 10'(rel) + 10'd15;
    if (r15 >= 10'd360) begin
      r15 = r15 - 10'd360;
    end
    clk_pos = '0;
    for (int k = 1; k < 12; k++) begin
      if (r15 >= 10'(30 * k)) begin
        clk_pos = clk_pos + 4'd1;
      end
    end
    dcount = '0;
    for (int c = 1; c < 10; c++) begin
      if (best_d2 >= dist_thr(4'(c), is_nm)) begin
        dcount = dcount + 4'd1;
      end
    end
    ahund = '0;
    for (int k = 1; k < 6; k++) begin
      if (is_ft) begin
        if (alt_prod >= 43'(64'(k) * 64'd1000000000)) begin
          ahund = ahund + 3'd1;
        end
      end else if (abs_v >= 17'(100 * k)) begin
        ahund = ahund + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units_mode   <= 2'd0;
      voice_expiry <= 16'd5;
      entry_expiry <= 16'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNITS: units_mode   <= cfg_data[1:0];
        CFG_VOICE: voice_expiry <= cfg_data;
        CFG_ENTRY: entry_expiry <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_announced <= '0;
      m_tvalid       <= 1'b0;
      cdc_start      <= 1'b0;
      found          <= 1'b0;
      idx            <= '0;
    end else begin
      cdc_start <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req        <= in_req;
            now        <= s_tdata[58:27];
            track      <= s_tdata[115:107];
            idx        <= '0;
            found      <= 1'b0;
            r_announce <= 1'b0;
            r_clock    <= '0;
            r_dnear    <= 1'b0;
            r_dcount   <= '0;
            r_anear    <= 1'b0;
            r_ahund    <= '0;
            r_above    <= 1'b0;
            r_code     <= '0;
            r_nm       <= 1'b0;
            r_ft       <= 1'b0;
            if ((in_req == REQ_ANNOUNCE) || (in_req == REQ_SWEEP)) begin
              state <= S_READ;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if ((req == REQ_ANNOUNCE) && live && (!found || (d2 < best_d2))) begin
            found     <= 1'b1;
            best_d2   <= d2;
            best_code <= rd.code;
            best_n    <= rd.north;
            best_e    <= rd.east;
            best_v    <= rd.vertical;
          end
          if (last_slot) begin
            state <= (req == REQ_ANNOUNCE) ? S_ANG : S_OUT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_READ;
          end
        end
        S_ANG: begin
          if (!found || (best_code == last_announced)) begin
            state <= S_OUT;
          end else begin
            last_announced <= best_code;
            swap      <= (an > ae);
            small_op  <= (an > ae) ? ae : an;
            big_op    <= (an > ae) ? an : ae;
            abs_v     <= best_v[15] ? 17'(-{best_v[15], best_v})
                                    : 17'({best_v[15], best_v});
            cdc_start <= 1'b1;
            state     <= S_CDC;
          end
        end
        S_CDC: begin
          alt_prod <= 43'(abs_v) * 43'(FEET_NUM);
          if (cdc_done) begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          deg   <= mag[23:16];
          neg   <= best_n[15];
          state <= S_FIN2;
        end
        S_FIN2: begin
          r_announce <= 1'b1;
          r_clock    <= clk_pos;
          r_dnear    <= (best_d2 < dist_thr(4'd1, is_nm));
          r_dcount   <= dcount;
          r_anear    <= (ahund == 3'd0);
          r_ahund    <= ahund;
          r_above    <= (ahund != 3'd0) && !best_v[15] && (best_v != 16'sd0);
          r_code     <= best_code;
          r_nm       <= is_nm;
          r_ft       <= is_ft;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= r_announce;
            m_tdata  <= {4'd0, r_ft, r_nm, live_count, r_code, r_above, r_ahund,
                         r_anear, r_dcount, r_dnear, r_clock};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
